FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Field widths fixed by the bus sequencer
  localparam int unsigned ActionWidth   = 3;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned HalfBitWidth  = 16;
  localparam int unsigned TimeoutWidth  = 8;
  localparam int unsigned BitCntWidth   = 4;
  localparam int unsigned StepWidth     = 4;
  localparam int unsigned CfgAddrWidth  = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned TimerWidthDef = 16;

  // Register reset values
  localparam logic [HalfBitWidth-1:0] HalfBitReset    = 16'd200;
  localparam logic [TimeoutWidth-1:0] AckTimeoutReset = 8'd250;

  // Register indexes (taken from paddr[2])
  localparam logic RegHalfBit    = 1'b0;
  localparam logic RegAckTimeout = 1'b1;

  // Command codes
  localparam logic [ActionWidth-1:0] ActNone  = 3'd0;
  localparam logic [ActionWidth-1:0] ActStart = 3'd1;
  localparam logic [ActionWidth-1:0] ActStop  = 3'd2;
  localparam logic [ActionWidth-1:0] ActWrite = 3'd3;
  localparam logic [ActionWidth-1:0] ActRead  = 3'd4;
  localparam logic [ActionWidth-1:0] ActAck   = 3'd5;

  // Register contents seen by the sequencer
  typedef struct packed {
    logic [HalfBitWidth-1:0] half_bit_ticks;
    logic [TimeoutWidth-1:0] ack_timeout;
  } cfg_t;

endpackage

FILE: rtl/i2cm_cmd_if.sv
interface i2cm_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [i2cm_pkg::ActionWidth-1:0]  action;
  logic [i2cm_pkg::ByteWidth-1:0]    tx_byte;
  logic                              ack_after_read;
  logic                              sda_in;

  modport source (output valid, action, tx_byte, ack_after_read, sda_in, input ready);
  modport sink   (input valid, action, tx_byte, ack_after_read, sda_in, output ready);
endinterface

FILE: rtl/i2cm_res_if.sv
interface i2cm_res_if;
  logic                            valid;
  logic                            ready;
  logic                            scl_out;
  logic                            sda_out;
  logic                            busy_res;
  logic                            done_res;
  logic [i2cm_pkg::ByteWidth-1:0]  rx_byte;
  logic                            ack_error;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_error,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_error,
                  output ready);
endinterface

FILE: rtl/i2cm_cfg_regs.sv
module i2cm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cm_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [i2cm_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [i2cm_pkg::CfgDataWidth-1:0]   prdata,
  output logic                                pready,
  output i2cm_pkg::cfg_t                      cfg_o
);

  logic [i2cm_pkg::HalfBitWidth-1:0] half_bit_q;
  logic [i2cm_pkg::TimeoutWidth-1:0] timeout_q;
  logic                              wr_en;
  logic                              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q <= i2cm_pkg::HalfBitReset;
      timeout_q  <= i2cm_pkg::AckTimeoutReset;
    end else if (wr_en) begin
      if (reg_sel == i2cm_pkg::RegHalfBit) begin
        half_bit_q <= pwdata[i2cm_pkg::HalfBitWidth-1:0];
      end else begin
        timeout_q <= pwdata[i2cm_pkg::TimeoutWidth-1:0];
      end
    end
  end

  // Read back the selected register
  always_comb begin
    if (reg_sel == i2cm_pkg::RegHalfBit) begin
      prdata = {{(i2cm_pkg::CfgDataWidth-i2cm_pkg::HalfBitWidth){1'b0}}, half_bit_q};
    end else begin
      prdata = {{(i2cm_pkg::CfgDataWidth-i2cm_pkg::TimeoutWidth){1'b0}}, timeout_q};
    end
  end

  assign cfg_o.half_bit_ticks = half_bit_q;
  assign cfg_o.ack_timeout    = timeout_q;

endmodule

FILE: rtl/i2cm_seq.sv
module i2cm_seq #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::TimerWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2cm_pkg::cfg_t  cfg_i,
  i2cm_cmd_if.sink        cmd_i,
  i2cm_res_if.source      res_o
);

  // Sequence steps
  localparam logic [i2cm_pkg::StepWidth-1:0] SIdle = 4'd0;
  localparam logic [i2cm_pkg::StepWidth-1:0] SStA  = 4'd1;
  localparam logic [i2cm_pkg::StepWidth-1:0] SStB  = 4'd2;
  localparam logic [i2cm_pkg::StepWidth-1:0] SSpA  = 4'd3;
  localparam logic [i2cm_pkg::StepWidth-1:0] SSpB  = 4'd4;
  localparam logic [i2cm_pkg::StepWidth-1:0] SWrA  = 4'd5;
  localparam logic [i2cm_pkg::StepWidth-1:0] SWrB  = 4'd6;
  localparam logic [i2cm_pkg::StepWidth-1:0] SWrC  = 4'd7;
  localparam logic [i2cm_pkg::StepWidth-1:0] SRdA  = 4'd8;
  localparam logic [i2cm_pkg::StepWidth-1:0] SRdB  = 4'd9;
  localparam logic [i2cm_pkg::StepWidth-1:0] SAkA  = 4'd10;
  localparam logic [i2cm_pkg::StepWidth-1:0] SAkB  = 4'd11;
  localparam logic [i2cm_pkg::StepWidth-1:0] SWaA  = 4'd12;
  localparam logic [i2cm_pkg::StepWidth-1:0] SWaB  = 4'd13;
  localparam logic [i2cm_pkg::StepWidth-1:0] SPoll = 4'd14;

  localparam logic [31:0] TimerMax = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  localparam int unsigned BW = i2cm_pkg::ByteWidth;

  logic [i2cm_pkg::StepWidth-1:0]    step_q, step_d;
  logic [TIMER_WIDTH-1:0]            timer_q, timer_d;
  logic [i2cm_pkg::BitCntWidth-1:0]  bitc_q, bitc_d, bitc_inc;
  logic [BW-1:0]                     shift_q, shift_d;
  logic [i2cm_pkg::TimeoutWidth-1:0] poll_q, poll_d, poll_base;
  logic                              ackc_q, ackc_d;
  logic                              scl_q, scl_d;
  logic                              sda_q, sda_d;
  logic                              err_q, err_d;
  logic [BW-1:0]                     rx_q, rx_d;
  logic                              done_q, done_d;
  logic                              out_valid_q;
  logic                              take;
  logic [i2cm_pkg::HalfBitWidth-1:0] half_m1;
  logic [31:0]                       half_wide;
  logic [TIMER_WIDTH-1:0]            reload;
  logic                              give_up;

  // Accept a tick whenever the result slot is free or being drained
  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign take        = cmd_i.valid && cmd_i.ready;

  // Phase reload: half_bit_ticks - 1, zero stays zero, saturate to the timer width
  assign half_m1   = (cfg_i.half_bit_ticks != '0) ? cfg_i.half_bit_ticks - 1'b1 : '0;
  assign half_wide = {{(32-i2cm_pkg::HalfBitWidth){1'b0}}, half_m1};
  assign reload    = (half_wide > TimerMax) ? TimerMax[TIMER_WIDTH-1:0]
                                            : half_wide[TIMER_WIDTH-1:0];

  // The first poll after the second wait phase starts from zero
  assign poll_base = (step_q == SPoll) ? poll_q : '0;
  assign give_up   = poll_base >= cfg_i.ack_timeout;
  assign bitc_inc  = bitc_q + 1'b1;

  // Next state for one tick
  always_comb begin
    step_d  = step_q;
    timer_d = timer_q;
    bitc_d  = bitc_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    ackc_d  = ackc_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    err_d   = err_q;
    rx_d    = rx_q;
    done_d  = 1'b0;

    if (step_q == SIdle) begin
      case (cmd_i.action)
        i2cm_pkg::ActStart: begin
          scl_d = 1'b1; sda_d = 1'b1; step_d = SStA; timer_d = reload;
        end
        i2cm_pkg::ActStop: begin
          scl_d = 1'b0; sda_d = 1'b0; step_d = SSpA; timer_d = reload;
        end
        i2cm_pkg::ActWrite: begin
          scl_d   = 1'b0;
          bitc_d  = '0;
          sda_d   = cmd_i.tx_byte[BW-1];
          shift_d = {cmd_i.tx_byte[BW-2:0], 1'b0};
          step_d  = SWrA;
          timer_d = reload;
        end
        i2cm_pkg::ActRead: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          bitc_d  = '0;
          shift_d = '0;
          ackc_d  = cmd_i.ack_after_read;
          step_d  = SRdA;
          timer_d = reload;
        end
        i2cm_pkg::ActAck: begin
          sda_d = 1'b1; step_d = SWaA; timer_d = reload;
        end
        default: ;
      endcase
    end else if (step_q == SPoll || (step_q == SWaB && timer_q == '0)) begin
      // Poll SDA for the acknowledge
      step_d  = SPoll;
      timer_d = '0;
      if (!cmd_i.sda_in) begin
        scl_d   = 1'b0;
        err_d   = 1'b0;
        step_d  = SIdle;
        done_d  = 1'b1;
        poll_d  = poll_base;
      end else if (give_up) begin
        err_d   = 1'b1;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        step_d  = SSpA;
        timer_d = reload;
        poll_d  = poll_base;
      end else begin
        poll_d = poll_base + 1'b1;
      end
    end else if (timer_q != '0) begin
      timer_d = timer_q - 1'b1;
    end else begin
      // End of a phase
      timer_d = reload;
      case (step_q)
        SStA: begin sda_d = 1'b0; step_d = SStB; end
        SStB: begin scl_d = 1'b0; step_d = SIdle; timer_d = '0; done_d = 1'b1; end
        SSpA: begin scl_d = 1'b1; sda_d = 1'b1; step_d = SSpB; end
        SSpB: begin step_d = SIdle; timer_d = '0; done_d = 1'b1; end
        SWrA: begin scl_d = 1'b1; step_d = SWrB; end
        SWrB: begin scl_d = 1'b0; step_d = SWrC; end
        SWrC: begin
          bitc_d = bitc_inc;
          if (bitc_inc[3]) begin
            step_d = SIdle; timer_d = '0; done_d = 1'b1;
          end else begin
            sda_d   = shift_q[BW-1];
            shift_d = {shift_q[BW-2:0], 1'b0};
            step_d  = SWrA;
          end
        end
        SRdA: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[BW-2:0], cmd_i.sda_in};
          bitc_d  = bitc_inc;
          step_d  = SRdB;
        end
        SRdB: begin
          scl_d = 1'b0;
          if (bitc_q[3]) begin
            rx_d   = shift_q;
            sda_d  = !ackc_q;
            step_d = SAkA;
          end else begin
            step_d = SRdA;
          end
        end
        SAkA: begin scl_d = 1'b1; step_d = SAkB; end
        SAkB: begin scl_d = 1'b0; step_d = SIdle; timer_d = '0; done_d = 1'b1; end
        SWaA: begin scl_d = 1'b1; step_d = SWaB; end
        default: begin step_d = SIdle; timer_d = '0; done_d = 1'b1; end
      endcase
    end
  end

  // Advance state on each accepted tick; the state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= SIdle;
      timer_q <= '0;
      bitc_q  <= '0;
      shift_q <= '0;
      poll_q  <= '0;
      ackc_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      err_q   <= 1'b0;
      rx_q    <= '0;
      done_q  <= 1'b0;
    end else if (take) begin
      step_q  <= step_d;
      timer_q <= timer_d;
      bitc_q  <= bitc_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      ackc_q  <= ackc_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      err_q   <= err_d;
      rx_q    <= rx_d;
      done_q  <= done_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_out   = scl_q;
  assign res_o.sda_out   = sda_q;
  assign res_o.busy_res  = (step_q != SIdle);
  assign res_o.done_res  = done_q;
  assign res_o.rx_byte   = rx_q;
  assign res_o.ack_error = err_q;

endmodule

FILE: rtl/i2c_master_byte_engine.sv
// I2C master bus sequencer. Every request on cmd_i is one time-base tick and
// yields exactly one result on res_o with the SCL/SDA levels and status after
// that tick. A tick is taken in every clock cycle unless res_o stalls; the
// sequencer state itself forms the result register, so a new tick is accepted
// whenever the previous result has been taken or is taken in the same cycle.
// Commands (start, stop, write byte, read byte with ACK/NACK, wait for ACK)
// are only acted on while the sequencer is idle; each bus phase lasts
// half_bit_ticks ticks (register 0, byte address 0) and the acknowledge wait
// gives up after ack_timeout high polls (register 1, byte address 4), issuing
// a stop and setting ack_error. Write the registers only while idle.
module i2c_master_byte_engine #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::TimerWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cm_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [i2cm_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [i2cm_pkg::CfgDataWidth-1:0]  prdata,
  output logic                               pready,
  i2cm_cmd_if.sink                           cmd_i,
  i2cm_res_if.source                         res_o
);

  i2cm_pkg::cfg_t cfg;

  // Configuration registers
  i2cm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Bus sequencer
  i2cm_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd_i),
    .res_o  (res_o)
  );

endmodule

FILE: tb/tb_i2c_master_byte_engine.sv
module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned RandomTicks   = 300;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles    = 20;

  localparam logic [CfgAddrWidth-1:0] AddrHalfBit    = {RegHalfBit, 2'b00};
  localparam logic [CfgAddrWidth-1:0] AddrAckTimeout = {RegAckTimeout, 2'b00};

  // Action codes with no command behind them
  localparam logic [ActionWidth-1:0] ActSpareLo = 3'd6;
  localparam logic [ActionWidth-1:0] ActSpareHi = 3'd7;

  typedef enum logic [4:0] {
    StIdle, StStartA, StStartB, StStopA, StStopB, StWrA, StWrB, StWrC,
    StRdA, StRdB, StAckOutA, StAckOutB, StWaitA, StWaitB, StPoll
  } bus_step_e;

  typedef struct packed {
    logic                 scl;
    logic                 sda;
    logic                 busy;
    logic                 done;
    logic [ByteWidth-1:0] rx;
    logic                 err;
  } bus_status_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  i2cm_cmd_if cmd_if ();
  i2cm_res_if res_if ();

  i2c_master_byte_engine u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_i   (cmd_if),
    .res_o   (res_if)
  );

  // Bus sequencer mirror
  logic [HalfBitWidth-1:0] half_cfg    = HalfBitReset;
  logic [TimeoutWidth-1:0] timeout_cfg = AckTimeoutReset;
  bus_step_e               step_q      = StIdle;
  logic [HalfBitWidth-1:0] timer_q     = '0;
  logic [BitCntWidth-1:0]  bits_q      = '0;
  logic [ByteWidth-1:0]    shreg_q     = '0;
  logic [TimeoutWidth-1:0] polls_q     = '0;
  logic                    ack_sel_q   = 1'b0;
  logic                    scl_q       = 1'b1;
  logic                    sda_q       = 1'b1;
  logic                    err_q       = 1'b0;
  logic                    done_q      = 1'b0;
  logic [ByteWidth-1:0]    rx_q        = '0;

  bus_status_t pending_status[$];

  int unsigned n_errors   = 0;
  int unsigned n_cycles   = 0;
  int unsigned n_live     = 0;
  int unsigned n_cmds     = 0;
  int unsigned n_done     = 0;
  int unsigned n_timeouts = 0;
  int unsigned n_reads    = 0;
  int unsigned n_holdoffs = 0;

  // Idling controls for the sender (gap_max, burst_left) and the receiver (stall_max, hold_off_req)
  int unsigned gap_max       = 3;
  int unsigned stall_max     = 4;
  int unsigned burst_left    = 0;
  bit          hold_off_req  = 1'b0;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Enter a delay phase with the timer reloaded
  function automatic void load_phase(input bus_step_e nxt);
    step_q  = nxt;
    timer_q = (half_cfg == '0) ? '0 : half_cfg - 16'd1;
  endfunction

  function automatic void finish_cmd();
    step_q  = StIdle;
    timer_q = '0;
    done_q  = 1'b1;
    n_done++;
  endfunction

  function automatic void shift_out_bit();
    sda_q   = shreg_q[7];
    shreg_q = {shreg_q[6:0], 1'b0};
  endfunction

  // One poll of SDA during the acknowledge wait
  function automatic void sample_ack(input logic sda);
    if (!sda) begin
      scl_q = 1'b0;
      err_q = 1'b0;
      finish_cmd();
    end else if (polls_q >= timeout_cfg) begin
      err_q = 1'b1;
      scl_q = 1'b0;
      sda_q = 1'b0;
      n_timeouts++;
      load_phase(StStopA);
    end else begin
      polls_q = polls_q + 8'd1;
    end
  endfunction

  function automatic void close_phase(input logic sda);
    case (step_q)
      StStartA: begin
        sda_q = 1'b0;
        load_phase(StStartB);
      end
      StStartB: begin
        scl_q = 1'b0;
        finish_cmd();
      end
      StStopA: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        load_phase(StStopB);
      end
      StStopB: finish_cmd();
      StWrA: begin
        scl_q = 1'b1;
        load_phase(StWrB);
      end
      StWrB: begin
        scl_q = 1'b0;
        load_phase(StWrC);
      end
      StWrC: begin
        bits_q = bits_q + 4'd1;
        if (bits_q >= 4'd8) begin
          finish_cmd();
        end else begin
          shift_out_bit();
          load_phase(StWrA);
        end
      end
      StRdA: begin
        scl_q   = 1'b1;
        shreg_q = {shreg_q[6:0], sda};
        bits_q  = bits_q + 4'd1;
        load_phase(StRdB);
      end
      StRdB: begin
        scl_q = 1'b0;
        if (bits_q >= 4'd8) begin
          rx_q  = shreg_q;
          sda_q = ~ack_sel_q;
          n_reads++;
          load_phase(StAckOutA);
        end else begin
          load_phase(StRdA);
        end
      end
      StAckOutA: begin
        scl_q = 1'b1;
        load_phase(StAckOutB);
      end
      StAckOutB: begin
        scl_q = 1'b0;
        finish_cmd();
      end
      StWaitA: begin
        scl_q = 1'b1;
        load_phase(StWaitB);
      end
      StWaitB: begin
        step_q  = StPoll;
        timer_q = '0;
        polls_q = '0;
        sample_ack(sda);
      end
      default: finish_cmd();
    endcase
  endfunction

  function automatic void start_cmd(input logic [ActionWidth-1:0] act,
                                    input logic [ByteWidth-1:0] tx, input logic ack);
    case (act)
      ActStart: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        load_phase(StStartA);
      end
      ActStop: begin
        scl_q = 1'b0;
        sda_q = 1'b0;
        load_phase(StStopA);
      end
      ActWrite: begin
        scl_q   = 1'b0;
        bits_q  = '0;
        shreg_q = tx;
        shift_out_bit();
        load_phase(StWrA);
      end
      ActRead: begin
        scl_q     = 1'b0;
        sda_q     = 1'b1;
        bits_q    = '0;
        shreg_q   = '0;
        ack_sel_q = ack;
        load_phase(StRdA);
      end
      ActAck: begin
        sda_q = 1'b1;
        load_phase(StWaitA);
      end
      default: ;
    endcase
  endfunction

  // Advance the mirror by one tick and return the bus status after it
  function automatic bus_status_t bus_tick(input logic [ActionWidth-1:0] act,
                                           input logic [ByteWidth-1:0] tx,
                                           input logic ack, input logic sda);
    logic is_cmd;
    is_cmd = (act >= ActStart) && (act <= ActAck);
    done_q = 1'b0;
    if (step_q != StIdle || is_cmd) n_live++;
    if (step_q == StIdle) begin
      if (is_cmd) n_cmds++;
      start_cmd(act, tx, ack);
    end else if (step_q == StPoll) begin
      sample_ack(sda);
    end else if (timer_q != '0) begin
      timer_q = timer_q - 16'd1;
    end else begin
      close_phase(sda);
    end
    return '{scl: scl_q, sda: sda_q, busy: (step_q != StIdle), done: done_q,
             rx: rx_q, err: err_q};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Predict on every accepted request, then compare every accepted result
  always @(posedge clk_i) begin : monitor
    bus_status_t got;
    bus_status_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      pending_status.push_back(bus_tick(cmd_if.action, cmd_if.tx_byte,
                                        cmd_if.ack_after_read, cmd_if.sda_in));
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{scl: res_if.scl_out, sda: res_if.sda_out, busy: res_if.busy_res,
              done: res_if.done_res, rx: res_if.rx_byte, err: res_if.ack_error};
      if (pending_status.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("scl_out", want.scl, got.scl);
        check_field("sda_out", want.sda, got.sda);
        check_field("busy_res", want.busy, got.busy);
        check_field("done_res", want.done, got.done);
        check_field("rx_byte", want.rx, got.rx);
        check_field("ack_error", want.err, got.err);
      end
    end
  end

  // Receiver: ready in runs, random stalls, and a long hold-off on request
  initial begin : receiver
    int unsigned run;
    res_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      res_if.ready <= 1'b1;
      run = $urandom_range(24, 1);
      repeat (run) @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n_holdoffs++;
        res_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (stall_max != 0) begin
        run = $urandom_range(stall_max);
        if (run != 0) begin
          res_if.ready <= 1'b0;
          repeat (run) @(negedge clk_i);
        end
      end
    end
  end

  // Offer one request, in bursts with random gaps; returns at a falling edge
  task automatic send_request(input logic [ActionWidth-1:0] act,
                              input logic [ByteWidth-1:0] tx, input logic ack,
                              input logic sda);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    cmd_if.valid          <= 1'b1;
    cmd_if.action         <= act;
    cmd_if.tx_byte        <= tx;
    cmd_if.ack_after_read <= ack;
    cmd_if.sda_in         <= sda;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic pick_sda(input int unsigned low_pct);
    return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
  endfunction

  // Commands sent while busy must be ignored, so mix some in
  function automatic logic [ActionWidth-1:0] busy_action();
    return ($urandom_range(3) == 0) ? ActionWidth'($urandom_range(7)) : ActNone;
  endfunction

  // Issue one command and tick until the sequencer is idle again
  task automatic run_cmd(input logic [ActionWidth-1:0] act, input logic [ByteWidth-1:0] tx,
                         input logic ack, input int unsigned low_pct);
    send_request(act, tx, ack, pick_sda(low_pct));
    while (step_q != StIdle) begin
      send_request(busy_action(), ByteWidth'($urandom), 1'($urandom), pick_sda(low_pct));
    end
  endtask

  // Drop valid and wait until every outstanding result has been checked
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic settle_bus();
    while (step_q != StIdle) begin
      send_request(ActNone, ByteWidth'($urandom), 1'($urandom), 1'($urandom));
    end
    wait_drained();
  endtask

  task automatic check_reg(input string name, input logic [CfgAddrWidth-1:0] addr,
                           input logic [CfgDataWidth-1:0] want);
    logic [CfgDataWidth-1:0] got;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    check_field(name, want, got);
  endtask

  // Write a register once the bus is idle, mirror it and read it back
  task automatic write_reg(input logic [CfgAddrWidth-1:0] addr,
                           input logic [CfgDataWidth-1:0] data);
    settle_bus();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    if (addr == AddrHalfBit) begin
      half_cfg = data[HalfBitWidth-1:0];
      check_reg("half_bit_ticks", addr, CfgDataWidth'(half_cfg));
    end else begin
      timeout_cfg = data[TimeoutWidth-1:0];
      check_reg("ack_timeout", addr, CfgDataWidth'(timeout_cfg));
    end
  endtask

  task automatic configure(input int unsigned half, input int unsigned timeout);
    write_reg(AddrHalfBit, CfgDataWidth'(half));
    write_reg(AddrAckTimeout, CfgDataWidth'(timeout));
  endtask

  function automatic int unsigned ack_pct();
    case ($urandom_range(3))
      0:       return 100;
      1:       return 40;
      2:       return 10;
      default: return 0;
    endcase
  endfunction

  // Well-formed transfer: start, address, ack, some data bytes, mostly a stop
  task automatic i2c_transfer();
    int unsigned nbytes;
    bit          reading;
    nbytes  = $urandom_range(3, 1);
    reading = 1'($urandom);
    run_cmd(ActStart, ByteWidth'($urandom), 1'($urandom), 50);
    run_cmd(ActWrite, ByteWidth'($urandom), 1'($urandom), 50);
    run_cmd(ActAck, ByteWidth'($urandom), 1'($urandom), ack_pct());
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (reading) begin
        run_cmd(ActRead, ByteWidth'($urandom), (i + 1 < nbytes) ? 1'b1 : 1'($urandom), 50);
      end else begin
        run_cmd(ActWrite, ByteWidth'($urandom), 1'($urandom), 50);
        run_cmd(ActAck, ByteWidth'($urandom), 1'($urandom), ack_pct());
      end
    end
    if ($urandom_range(9) != 0) run_cmd(ActStop, ByteWidth'($urandom), 1'($urandom), 50);
    repeat ($urandom_range(2)) send_request(ActNone, ByteWidth'($urandom), 1'($urandom),
                                           1'($urandom));
  endtask

  task automatic noise_cmds();
    repeat ($urandom_range(4, 1)) begin
      run_cmd(ActionWidth'($urandom_range(7)), ByteWidth'($urandom), 1'($urandom),
              $urandom_range(100));
    end
  endtask

  task automatic traffic(input int unsigned n_ticks);
    int unsigned first;
    first = n_live;
    while (n_live - first < n_ticks) begin
      if ($urandom_range(9) < 8) i2c_transfer();
      else noise_cmds();
    end
  endtask

  // Reset values of both registers, then one slow start
  task automatic test_reset_defaults();
    check_reg("half_bit_ticks", AddrHalfBit, CfgDataWidth'(HalfBitReset));
    check_reg("ack_timeout", AddrAckTimeout, CfgDataWidth'(AckTimeoutReset));
    run_cmd(ActStart, 8'h00, 1'b0, 50);
  endtask

  task automatic test_directed_commands();
    configure(1, 3);
    run_cmd(ActStart, 8'h00, 1'b0, 50);
    run_cmd(ActWrite, 8'h00, 1'b0, 50);
    run_cmd(ActAck, 8'h00, 1'b0, 100);
    run_cmd(ActWrite, 8'hFF, 1'b1, 50);
    // never acknowledged: stop issued and error raised
    run_cmd(ActAck, 8'h00, 1'b0, 0);
    run_cmd(ActStart, 8'h00, 1'b0, 50);
    run_cmd(ActWrite, 8'hA5, 1'b0, 50);
    run_cmd(ActAck, 8'h00, 1'b0, 30);
    run_cmd(ActRead, 8'h00, 1'b1, 0);
    run_cmd(ActRead, 8'hFF, 1'b0, 100);
    run_cmd(ActRead, 8'h00, 1'b1, 50);
    run_cmd(ActStop, 8'h00, 1'b0, 50);
    // SCL left high by the stop, so the wait keeps it high at first
    run_cmd(ActAck, 8'h00, 1'b0, 100);
    run_cmd(ActNone, 8'hFF, 1'b1, 50);
    run_cmd(ActSpareLo, 8'hFF, 1'b1, 50);
    run_cmd(ActSpareHi, 8'hFF, 1'b1, 50);
    configure(3, 1);
    run_cmd(ActWrite, 8'h5A, 1'b0, 50);
    run_cmd(ActRead, 8'h00, 1'b0, 50);
  endtask

  task automatic test_config_extremes();
    // zero delay acts as one tick, zero timeout gives up on the first high poll
    configure(0, 0);
    run_cmd(ActStart, 8'h00, 1'b0, 50);
    run_cmd(ActAck, 8'h00, 1'b0, 0);
    run_cmd(ActAck, 8'h00, 1'b0, 100);
    run_cmd(ActRead, 8'h00, 1'b1, 50);
    run_cmd(ActStop, 8'h00, 1'b0, 50);
    configure(1, 255);
    run_cmd(ActAck, 8'h00, 1'b0, 0);
    // largest delay: written and read back only
    configure(65535, 1);
  endtask

  // Long receiver hold-off while requests keep coming, then pause the sender
  task automatic test_backpressure();
    configure(1, 6);
    gap_max      = 0;
    hold_off_req = 1'b1;
    repeat (3) i2c_transfer();
    wait_drained();
    gap_max = 3;
  endtask

  task automatic test_random_traffic();
    int unsigned share;
    share     = RandomTicks / 4;
    gap_max   = 0;
    stall_max = 0;
    configure(1, $urandom_range(6, 1));
    traffic(share);
    gap_max   = 6;
    stall_max = 5;
    configure(2, $urandom_range(12, 1));
    traffic(share);
    gap_max   = 3;
    stall_max = 8;
    configure($urandom_range(4, 1), $urandom_range(255, 1));
    traffic(share);
    gap_max   = 10;
    stall_max = 3;
    configure(1, $urandom_range(20, 1));
    traffic(share);
  endtask

  initial begin : main
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.action         = ActNone;
    cmd_if.tx_byte        = '0;
    cmd_if.ack_after_read = 1'b0;
    cmd_if.sda_in         = 1'b1;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed_commands();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    settle_bus();
    repeat (TailCycles) @(negedge clk_i);
    if (pending_status.size() != 0) begin
      $error("%0d results never arrived", pending_status.size());
      n_errors++;
    end

    $display("Ran %0d active ticks, %0d commands, %0d completions", n_live, n_cmds, n_done);
    $display("Saw %0d byte reads, %0d ack timeouts, %0d receiver hold-offs",
             n_reads, n_timeouts, n_holdoffs);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
